// ===== hw/rtl/msk_pkg.sv =====
// Package for the min-tracking stack: depth, derived widths, codes and types.
// Used by min_tracking_stack and the testbench; depends on nothing.
`default_nettype none

package msk_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] EMPTY_MIN_RESET = 32'sd10000000;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_EMPTY  = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

endpackage

`default_nettype wire

// ===== hw/rtl/min_tracking_stack.sv =====
// Top level of the min-tracking stack: control, counters and the two stores.
// Depends on msk_pkg and msk_ram.
//
//   Channel  Dir  Handshake            Contents
//   in_      in   in_tvalid/in_tready  tuser: command; tdata: value
//   out_     out  out_tvalid/out_tready tdata: top, minimum, empty, full, status
//   cfg_     in   cfg_we               cfg_wdata: empty_minimum
//
// Every request is accepted in the idle state, while both stores are read at the
// entry below the top, and executed in the exec state, when the read data has
// arrived and the update is written back. The next request is taken while a
// result still waits in the output register; execution stalls only when that
// register is full and out_tready is low. Reset is synchronous and active low and
// empties the stack; the stores themselves are never cleared.
`default_nettype none

module min_tracking_stack (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [0:0]  in_tuser,   // [0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata,  // [31:0] top_value, [63:32] minimum_value,
                                       // [64] is_empty, [65] is_full,
                                       // [67:66] status, [71:68] zero
  input  wire logic        cfg_we,
  input  wire logic signed [31:0] cfg_wdata
);

  localparam int AW = msk_pkg::ADDR_W;
  localparam int CW = msk_pkg::CNT_W;
  localparam int DW = msk_pkg::DATA_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(msk_pkg::DEPTH);

  msk_pkg::fsm_t fsm_r, fsm_nxt;

  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          mcount_r, mcount_nxt;
  logic signed [DW-1:0]   cur_min_r, cur_min_nxt;
  logic signed [DW-1:0]   top_r, top_nxt;
  logic signed [DW-1:0]   empty_min_r;
  msk_pkg::cmd_t          cmd_r;
  logic signed [DW-1:0]   value_r;

  logic                   out_valid_r;
  logic [71:0]            out_data_r;

  logic                   ent_we, min_we;
  logic [AW-1:0]          ent_raddr, min_raddr;
  logic [DW-1:0]          ent_rdata, min_rdata;
  logic [CW-1:0]          ent_rsel, min_rsel;

  msk_pkg::status_t       status;
  logic                   exec_go;
  logic                   accept;
  logic signed [DW-1:0]   min_out;

  // Both stores are always read two below the counts: the entry that becomes
  // the top after a pop and the minimum that is restored after a pop.
  assign ent_rsel  = count_r - CW'(2);
  assign min_rsel  = mcount_r - CW'(2);
  assign ent_raddr = ent_rsel[AW-1:0];
  assign min_raddr = min_rsel[AW-1:0];

  msk_ram #(.WIDTH(DW), .DEPTH(msk_pkg::DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (count_r[AW-1:0]),
    .wdata (value_r),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  msk_ram #(.WIDTH(DW), .DEPTH(msk_pkg::DEPTH)) u_minimum_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (mcount_r[AW-1:0]),
    .wdata (value_r),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  assign in_tready  = (fsm_r == msk_pkg::FSM_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Execution waits while an earlier result has not been taken.
  assign exec_go = (fsm_r == msk_pkg::FSM_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    fsm_nxt     = fsm_r;
    count_nxt   = count_r;
    mcount_nxt  = mcount_r;
    cur_min_nxt = cur_min_r;
    top_nxt     = top_r;
    ent_we      = 1'b0;
    min_we      = 1'b0;
    status      = msk_pkg::ST_DONE;

    case (fsm_r)
      msk_pkg::FSM_IDLE: begin
        if (accept) begin
          fsm_nxt = msk_pkg::FSM_EXEC;
        end
      end
      msk_pkg::FSM_EXEC: begin
        if (exec_go) begin
          fsm_nxt = msk_pkg::FSM_IDLE;
          if (cmd_r == msk_pkg::CMD_PUSH) begin
            if (count_r == FULL_CNT) begin
              status = msk_pkg::ST_PUSH_FULL;
            end else begin
              ent_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              top_nxt   = value_r;
              if (mcount_r == '0 || value_r <= cur_min_r) begin
                if (mcount_r != FULL_CNT) begin
                  min_we     = 1'b1;
                  mcount_nxt = mcount_r + CW'(1);
                end
                cur_min_nxt = value_r;
              end
            end
          end else begin
            if (count_r == '0) begin
              status = msk_pkg::ST_POP_EMPTY;
            end else begin
              if (mcount_r != '0 && top_r == cur_min_r) begin
                mcount_nxt  = mcount_r - CW'(1);
                cur_min_nxt = (mcount_r == CW'(1)) ? empty_min_r : $signed(min_rdata);
              end
              count_nxt = count_r - CW'(1);
              top_nxt   = (count_r == CW'(1)) ? '0 : $signed(ent_rdata);
            end
          end
        end
      end
      default: begin
        fsm_nxt = msk_pkg::FSM_IDLE;
      end
    endcase
  end

  assign min_out = (count_nxt != '0) ? cur_min_nxt : empty_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= msk_pkg::FSM_IDLE;
      count_r     <= '0;
      mcount_r    <= '0;
      cur_min_r   <= msk_pkg::EMPTY_MIN_RESET;
      top_r       <= '0;
      empty_min_r <= msk_pkg::EMPTY_MIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r     <= fsm_nxt;
      count_r   <= count_nxt;
      mcount_r  <= mcount_nxt;
      cur_min_r <= cur_min_nxt;
      top_r     <= top_nxt;
      if (cfg_we) begin
        empty_min_r <= cfg_wdata;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= msk_pkg::cmd_t'(in_tuser[0]);
      value_r <= in_tdata;
    end
    if (exec_go) begin
      out_data_r <= {4'b0000,
                     status,
                     (count_nxt == FULL_CNT),
                     (count_nxt == '0),
                     min_out,
                     top_nxt};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msk_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used by min_tracking_stack for the entry and minimum stores.
`default_nettype none

module msk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sim/min_tracking_stack_checker.sv =====
// Checker for the min-tracking stack: watches the request, result and register
// ports, predicts each result from its own stack copy and compares field by field.
// Depends on msk_pkg.
`default_nettype none

module min_tracking_stack_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic        [31:0] in_tdata,   // [31:0] value
  input  wire logic        [0:0]  in_tuser,   // [0] command
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic        [71:0] out_tdata,  // [31:0] top, [63:32] minimum, [64] empty,
                                              // [65] full, [67:66] status, [71:68] zero
  input  wire logic               cfg_we,
  input  wire logic signed [31:0] cfg_wdata,
  output int                      error_count,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]         pad;
    msk_pkg::status_t   status;
    logic               full;
    logic               empty;
    logic signed [31:0] minimum;
    logic signed [31:0] top;
  } stack_view_t;

  logic signed [31:0] entries [msk_pkg::DEPTH];
  logic signed [31:0] minima  [msk_pkg::DEPTH];
  int                 entry_cnt;
  int                 min_cnt;
  logic signed [31:0] cur_min;
  logic signed [31:0] empty_min;
  stack_view_t        pending_views [$];
  stack_view_t        want;
  stack_view_t        got;

  function automatic stack_view_t predict_stack_step(msk_pkg::cmd_t cmd,
                                                     logic signed [31:0] value);
    stack_view_t      view;
    msk_pkg::status_t st;
    st = msk_pkg::ST_DONE;
    if (cmd == msk_pkg::CMD_PUSH) begin
      if (entry_cnt >= msk_pkg::DEPTH) begin
        st = msk_pkg::ST_PUSH_FULL;
      end else begin
        entries[entry_cnt] = value;
        entry_cnt++;
        // Ties go onto the minimum stack too, so a duplicate minimum survives a pop.
        if (min_cnt == 0 || value <= cur_min) begin
          if (min_cnt < msk_pkg::DEPTH) begin
            minima[min_cnt] = value;
            min_cnt++;
          end
          cur_min = value;
        end
      end
    end else if (entry_cnt == 0) begin
      st = msk_pkg::ST_POP_EMPTY;
    end else begin
      if (min_cnt > 0 && entries[entry_cnt-1] == cur_min) begin
        min_cnt--;
        cur_min = (min_cnt > 0) ? minima[min_cnt-1] : empty_min;
      end
      entry_cnt--;
    end
    view.pad     = '0;
    view.status  = st;
    view.full    = (entry_cnt >= msk_pkg::DEPTH);
    view.empty   = (entry_cnt == 0);
    view.top     = (entry_cnt > 0) ? entries[entry_cnt-1] : 32'sd0;
    view.minimum = (entry_cnt > 0) ? cur_min : empty_min;
    return view;
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s expected %h, got %h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      entry_cnt   = 0;
      min_cnt     = 0;
      empty_min   = msk_pkg::EMPTY_MIN_RESET;
      cur_min     = msk_pkg::EMPTY_MIN_RESET;
      error_count = 0;
      pending_views.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_views.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, got %h",
                   $time, out_tdata);
          error_count++;
        end else begin
          want = pending_views.pop_front();
          got  = out_tdata;
          check_field("top_value", want.top, got.top);
          check_field("minimum_value", want.minimum, got.minimum);
          check_field("is_empty", 32'(want.empty), 32'(got.empty));
          check_field("is_full", 32'(want.full), 32'(got.full));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("padding", 32'(want.pad), 32'(got.pad));
        end
      end
      if (in_tvalid && in_tready) begin
        pending_views.push_back(predict_stack_step(msk_pkg::cmd_t'(in_tuser[0]), in_tdata));
      end
      // A register write leaves the stored minimum alone; it only shows once empty.
      if (cfg_we) begin
        empty_min = cfg_wdata;
      end
    end
    outstanding = pending_views.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_min_tracking_stack.sv =====
// Top of the min-tracking stack testbench: clock, reset, push and pop requests,
// register writes and the verdict. Depends on msk_pkg, min_tracking_stack and
// min_tracking_stack_checker.
`default_nettype none

module tb_min_tracking_stack;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 500;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic        [31:0] in_tdata   = '0;
  logic        [0:0]  in_tuser   = '0;
  logic               out_tready = 1'b0;
  logic               cfg_we     = 1'b0;
  logic signed [31:0] cfg_wdata  = '0;
  logic               in_tready;
  logic               out_tvalid;
  logic        [71:0] out_tdata;

  int send_idle   = 0;
  int recv_stall  = 0;
  int cycle_count = 0;
  int error_count;
  int outstanding;

  min_tracking_stack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  min_tracking_stack_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[min_tracking_stack] ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(msk_pkg::cmd_t cmd, logic signed [31:0] value);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_empty_minimum(logic signed [31:0] value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(16) - 8;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Bursts lean toward pushes or pops so the stack swings between empty and full.
  task automatic run_random(int count);
    int left;
    int burst;
    int push_pct;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(120, 10);
      case ($urandom_range(4))
        0: push_pct = 90;
        1: push_pct = 15;
        2: begin
          push_pct = 100;
          burst    = 140;
        end
        3: push_pct = 0;
        default: push_pct = 55;
      endcase
      repeat (burst) begin
        if (left > 0) begin
          send_request(($urandom_range(99) < push_pct) ? msk_pkg::CMD_PUSH
                                                       : msk_pkg::CMD_POP,
                       pick_value());
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pops, extremes, duplicate minima and the reset empty minimum.
    send_request(msk_pkg::CMD_POP, $urandom);
    send_request(msk_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
    send_request(msk_pkg::CMD_PUSH, 32'sh8000_0000);
    send_request(msk_pkg::CMD_PUSH, 32'sh8000_0000);
    send_request(msk_pkg::CMD_PUSH, 32'sd0);
    send_request(msk_pkg::CMD_PUSH, -32'sd1);
    repeat (5) send_request(msk_pkg::CMD_POP, $urandom);
    send_request(msk_pkg::CMD_POP, 32'sh7FFF_FFFF);
    send_request(msk_pkg::CMD_PUSH, 32'sd10000000);
    send_request(msk_pkg::CMD_PUSH, 32'sd10000001);
    send_request(msk_pkg::CMD_POP, $urandom);
    send_request(msk_pkg::CMD_POP, $urandom);
    // A register write with an entry held only shows once the stack is empty.
    send_request(msk_pkg::CMD_PUSH, 32'sd5);
    write_empty_minimum(32'sh8000_0000);
    send_request(msk_pkg::CMD_PUSH, 32'sd7);
    send_request(msk_pkg::CMD_POP, $urandom);
    send_request(msk_pkg::CMD_POP, $urandom);
    send_request(msk_pkg::CMD_PUSH, 32'sd3);
    send_request(msk_pkg::CMD_POP, 32'sh0000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
          write_empty_minimum(32'sh7FFF_FFFF);
        end
        1: begin
          send_idle  = 81;
          recv_stall = 0;
          write_empty_minimum(32'sd0);
        end
        2: begin
          send_idle  = 0;
          recv_stall = 81;
          write_empty_minimum(-32'sd1);
        end
        default: begin
          send_idle  = 33;
          recv_stall = 33;
          write_empty_minimum($urandom);
        end
      endcase
      run_random(ITEMS_PER_PHASE / 2);
      drain_results();
      run_random(ITEMS_PER_PHASE / 2);
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("[min_tracking_stack] OK");
    end else begin
      $display("[min_tracking_stack] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/msk_pkg.sv
hw/rtl/msk_ram.sv
hw/rtl/min_tracking_stack.sv
sim/min_tracking_stack_checker.sv
sim/tb_min_tracking_stack.sv
